@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising edge of clk outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hca_pkg.sv @@
// shared types and constants for the hypergraph cut accumulator
package hca_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PIN   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int PART_W   = 6;
  localparam int NPARTS   = 64;
  localparam int COUNT_W  = 7;
  localparam int WEIGHT_W = 31;
  localparam int TOTAL_W  = 63;
  localparam int PROD_W   = WEIGHT_W + PART_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic valid;
    logic pin;
    logic clear;
    logic last;
    logic hit;
  } hca_ctl_t;

endpackage

@@ hw/rtl/hca_part_table.sv @@
// part table memory and the first pipeline stage
module hca_part_table import hca_pkg::*; #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                accept,
  input  logic [1:0]          op,
  input  logic [11:0]         vertex,
  input  logic [PART_W-1:0]   part,
  input  logic signed [31:0]  net_weight,
  input  logic                last_pin,
  input  logic [12:0]         vertex_count,
  output hca_ctl_t            s1_ctl,
  output logic [PART_W-1:0]   s1_part,
  output logic [WEIGHT_W-1:0] s1_weight
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic [PART_W-1:0] mem [MAX_VERTICES];
  logic [AW-1:0]     addr;
  logic              in_range;
  logic              below_count;
  logic              weight_low;

  assign addr        = AW'(vertex);
  assign in_range    = 32'(vertex) < 32'(MAX_VERTICES);
  assign below_count = {1'b0, vertex} < vertex_count;
  // zero or negative weights count as one
  assign weight_low  = net_weight[31] || (net_weight == 32'sd0);

  always_ff @(posedge clk) begin
    if (accept && (op == OP_WRITE) && in_range) begin
      mem[addr] <= part;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_part <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (advance) begin
      s1_ctl.valid <= accept;
      s1_ctl.pin   <= op == OP_PIN;
      s1_ctl.clear <= op == OP_CLEAR;
      s1_ctl.last  <= last_pin;
      s1_ctl.hit   <= in_range && below_count;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_weight <= weight_low ? WEIGHT_W'(1) : net_weight[WEIGHT_W-1:0];
    end
  end

endmodule

@@ hw/rtl/hca_touch.sv @@
// touched-part bitmap and distinct part count
module hca_touch import hca_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  hca_ctl_t            s1_ctl,
  input  logic [PART_W-1:0]   s1_part,
  input  logic [WEIGHT_W-1:0] s1_weight,
  output hca_ctl_t            s2_ctl,
  output logic [COUNT_W-1:0]  s2_count,
  output logic [WEIGHT_W-1:0] s2_weight
);

  `include "assert_macros.svh"

  function automatic logic [COUNT_W-1:0] popcount64(input logic [NPARTS-1:0] v);
    logic [3:0]         byte_sum;
    logic [COUNT_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < NPARTS / 8; b++) begin
      byte_sum = '0;
      for (int i = 0; i < 8; i++) begin
        byte_sum = byte_sum + 4'(v[b*8 + i]);
      end
      sum = sum + COUNT_W'(byte_sum);
    end
    return sum;
  endfunction

  logic [NPARTS-1:0] touched;
  logic [NPARTS-1:0] touched_next;
  logic              pin_go;

  assign pin_go = advance && s1_ctl.valid && s1_ctl.pin;

  always_comb begin
    touched_next = touched;
    if (s1_ctl.hit) begin
      touched_next = touched | (NPARTS'(1) << s1_part);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (pin_go) begin
      touched <= s1_ctl.last ? '0 : touched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (advance) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_count  <= popcount64(touched_next);
      s2_weight <= s1_weight;
    end
  end

  `ASSERT_NEXT(a_bitmap_cleared, pin_go && s1_ctl.last, touched == '0,
               "bitmap not cleared after last pin")
  `ASSERT_IMPL(a_count_range, s2_ctl.valid, s2_count <= COUNT_W'(NPARTS),
               "part count out of range")

endmodule

@@ hw/rtl/hca_accum.sv @@
// weight multiply, saturating total and result register
module hca_accum import hca_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  hca_ctl_t            s2_ctl,
  input  logic [COUNT_W-1:0]  s2_count,
  input  logic [WEIGHT_W-1:0] s2_weight,
  output hca_ctl_t            s3_ctl,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TOTAL_W-1:0]  total_cut,
  output logic [COUNT_W-1:0]  parts_touched
);

  `include "assert_macros.svh"

  logic [PART_W-1:0]  count_m1;
  logic [PROD_W-1:0]  product;
  logic [PROD_W-1:0]  s3_product;
  logic [COUNT_W-1:0] s3_count;
  logic [TOTAL_W-1:0] running_total;
  logic [TOTAL_W-1:0] total_next;
  logic [TOTAL_W:0]   sum;
  logic               result_go;
  logic               clear_go;

  // count of one or zero adds nothing
  assign count_m1 = (s2_count > COUNT_W'(1)) ? PART_W'(s2_count - COUNT_W'(1)) : '0;
  assign product  = {{PART_W{1'b0}}, s2_weight} * {{WEIGHT_W{1'b0}}, count_m1};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else if (advance) begin
      s3_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_product <= product;
      s3_count   <= s2_count;
    end
  end

  assign result_go = advance && s3_ctl.valid && s3_ctl.pin && s3_ctl.last;
  assign clear_go  = advance && s3_ctl.valid && s3_ctl.clear;

  assign sum        = {1'b0, running_total} + (TOTAL_W + 1)'(s3_product);
  assign total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (clear_go) begin
      running_total <= '0;
    end else if (result_go) begin
      running_total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_go) begin
      total_cut     <= total_next;
      parts_touched <= s3_count;
    end
  end

  `ASSERT_NEXT(a_result_shown, result_go, out_valid && (total_cut == running_total),
               "finished net not shown at output")

endmodule

@@ hw/rtl/hypergraph_cut_accumulator_top.sv @@
// top level of the hypergraph cut accumulator
// path: a net's last pin runs through stages 1, 2 and 3 into the output register
// throughput: one item per cycle; the four-stage pipe only holds while the output
//   register still has an untaken result and the item at the last stage produces one
// reset: rst is synchronous and clears pipeline valids, bitmap, total and vertex_count;
//   the part table is not cleared and must be written before use
module hypergraph_cut_accumulator_top import hca_pkg::*; #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_wen,
  input  logic [12:0]         cfg_wdata,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [11:0]         vertex,
  input  logic [PART_W-1:0]   part,
  input  logic signed [31:0]  net_weight,
  input  logic                last_pin,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TOTAL_W-1:0]  total_cut,
  output logic [COUNT_W-1:0]  parts_touched
);

  `include "assert_macros.svh"

  logic [12:0]         vertex_count;
  logic                advance;
  logic                accept;
  hca_ctl_t            s1_ctl;
  hca_ctl_t            s2_ctl;
  hca_ctl_t            s3_ctl;
  logic [PART_W-1:0]   s1_part;
  logic [WEIGHT_W-1:0] s1_weight;
  logic [COUNT_W-1:0]  s2_count;
  logic [WEIGHT_W-1:0] s2_weight;

  // vertex count register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wen) begin
      vertex_count <= cfg_wdata;
    end
  end

  // whole pipe moves together; it stops only when the last stage must
  // load a result into an output register that is still full
  assign advance  = !(out_valid && !out_ready && s3_ctl.valid && s3_ctl.pin && s3_ctl.last);
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // stage 1: table write, table read for the pin, weight clamp
  hca_part_table #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .accept       (accept),
    .op           (op),
    .vertex       (vertex),
    .part         (part),
    .net_weight   (net_weight),
    .last_pin     (last_pin),
    .vertex_count (vertex_count),
    .s1_ctl       (s1_ctl),
    .s1_part      (s1_part),
    .s1_weight    (s1_weight)
  );

  // stage 2: mark the part, count distinct parts on the last pin
  hca_touch u_touch (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .s1_ctl    (s1_ctl),
    .s1_part   (s1_part),
    .s1_weight (s1_weight),
    .s2_ctl    (s2_ctl),
    .s2_count  (s2_count),
    .s2_weight (s2_weight)
  );

  // stages 3 and 4: multiply, saturating add, output register
  hca_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .s2_ctl        (s2_ctl),
    .s2_count      (s2_count),
    .s2_weight     (s2_weight),
    .s3_ctl        (s3_ctl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .total_cut     (total_cut),
    .parts_touched (parts_touched)
  );

  `ASSERT_IMPL(a_stall_needs_full_out, !in_ready, out_valid && s3_ctl.valid,
               "input stalled without a pending result")

endmodule
